/* src/cts_pkg.sv */
`default_nettype none

package cts_pkg;

  typedef enum logic [2:0] {
    PH_SCAN   = 3'd0,
    PH_RUN    = 3'd1,
    PH_COLON  = 3'd2,
    PH_MIN1   = 3'd3,
    PH_SUFFIX = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_A_LOW  = 8'h61;
  localparam logic [7:0] CH_P_LOW  = 8'h70;

  localparam logic [6:0]  MAX_HOUR         = 7'd23;
  localparam logic [6:0]  MAX_MINUTE       = 7'd59;
  localparam logic [6:0]  NOON_HOUR        = 7'd12;
  localparam logic [12:0] MINUTES_PER_HOUR = 13'd60;
  localparam logic [10:0] DAY_MINUTES      = 11'(24 * 60);

  // Result of the text as it stands when the ending zero byte is taken
  typedef struct packed {
    logic        fire;
    logic [1:0]  status;
    logic [10:0] arrival;
    logic [10:0] now;
  } text_end_t;

  function automatic logic [6:0] mul10_add(input logic [6:0] v, input logic [3:0] d);
    logic [9:0] acc;
    acc = {v, 3'b000} + {2'b00, v, 1'b0} + {6'b0, d};
    return acc[6:0];
  endfunction

  // 12-hour rebase by the suffix character, then hour and minute to minute of day
  function automatic logic [10:0] rebased_minutes(input logic [6:0] hour,
                                                  input logic [6:0] minute,
                                                  input logic [7:0] c);
    logic [6:0]  h;
    logic [12:0] total;
    h = hour;
    if (c == CH_A || c == CH_A_LOW) begin
      if (h == NOON_HOUR) h = 7'd0;
    end else if (c == CH_P || c == CH_P_LOW) begin
      if (h < NOON_HOUR) h = h + NOON_HOUR;
    end
    total = {6'b0, h} * MINUTES_PER_HOUR + {6'b0, minute};
    return total[10:0];
  endfunction

endpackage

`default_nettype wire

/* src/clock_time_text_scanner.sv */
`default_nettype none

// Clock time scanner: takes a text one byte per transfer on the slave side and
// gives one result transfer per text, issued for the ending zero byte: a status,
// the first H:MM or HH:MM time found (with A/P 12-hour suffix applied) as a
// minute of day, and the minutes from the supplied current time until it,
// wrapped over midnight. One byte is taken every cycle at full rate. A zero
// byte passes the input register, then its result is stored in the result
// register. Non-zero bytes keep flowing while a result waits; only a zero byte
// meeting a full, stalled result register holds the input side.
module clock_time_text_scanner (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // text_byte[7:0], now_minute_of_day[18:8], zeros
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata    // scan_status[1:0], arrival_minute[12:2],
                                      // minutes_until[23:13]
);

  cts_pkg::text_end_t txt_end;
  logic               res_ready;

  cts_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .res_ready (res_ready),
    .txt_end   (txt_end)
  );

  cts_result u_result (
    .clk       (clk),
    .rst       (rst),
    .txt_end   (txt_end),
    .res_ready (res_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] == cts_pkg::ST_FOUND || m_tdata[1:0] == cts_pkg::ST_NONE ||
                  m_tdata[1:0] == cts_pkg::ST_RANGE))
    else $error("invalid scan status");

  a_found_in_day: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] == cts_pkg::ST_FOUND)
      |-> (m_tdata[12:2] < cts_pkg::DAY_MINUTES && m_tdata[23:13] < cts_pkg::DAY_MINUTES))
    else $error("found time outside the day");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] != cts_pkg::ST_FOUND) |-> (m_tdata[23:2] == 22'd0))
    else $error("times not cleared without a found time");

endmodule

`default_nettype wire

/* src/cts_scan.sv */
`default_nettype none

module cts_scan (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [23:0]          s_tdata,   // text_byte[7:0], now_minute_of_day[18:8], zeros
  input  wire logic                 res_ready,
  output cts_pkg::text_end_t        txt_end
);

  logic        in_full;
  logic [7:0]  in_byte;
  logic [10:0] in_now;
  logic        advance;
  logic        is_nul;

  cts_pkg::phase_t phase, phase_next;
  logic [1:0]  run_len, run_len_next;
  logic [6:0]  hour, hour_next;
  logic [6:0]  minute, minute_next;
  logic [10:0] parsed, parsed_next;
  logic [1:0]  status, status_next;

  logic        dig;
  logic [3:0]  d;
  logic [6:0]  hour_step;
  logic [6:0]  min_step;
  logic [7:0]  d_full;

  assign is_nul   = (in_byte == cts_pkg::CH_NUL);
  // a zero byte waits here until the result register can take it
  assign advance  = in_full && (!is_nul || res_ready);
  assign s_tready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tready) begin
      in_full <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata[7:0];
      in_now  <= s_tdata[18:8];
    end
  end

  assign dig       = (in_byte >= cts_pkg::CH_ZERO) && (in_byte <= cts_pkg::CH_NINE);
  assign d_full    = in_byte - cts_pkg::CH_ZERO;
  assign d         = dig ? d_full[3:0] : 4'd0;
  assign hour_step = cts_pkg::mul10_add(hour, d);
  assign min_step  = cts_pkg::mul10_add(minute, d);

  always_comb begin
    phase_next   = phase;
    run_len_next = run_len;
    hour_next    = hour;
    minute_next  = minute;
    parsed_next  = parsed;
    status_next  = status;
    unique case (phase)
      cts_pkg::PH_RUN: begin
        if (dig) begin
          if (run_len != 2'd3) begin
            run_len_next = run_len + 2'd1;
            if (run_len != 2'd2) hour_next = hour_step;
          end
        end else if (run_len != 2'd3 && in_byte == cts_pkg::CH_COLON) begin
          phase_next = cts_pkg::PH_COLON;
        end else begin
          phase_next = cts_pkg::PH_SCAN;
        end
      end
      cts_pkg::PH_COLON: begin
        if (dig) begin
          minute_next = {3'b000, d};
          phase_next  = cts_pkg::PH_MIN1;
        end else begin
          phase_next = cts_pkg::PH_SCAN;
        end
      end
      cts_pkg::PH_MIN1: begin
        if (dig) begin
          minute_next = min_step;
          if (hour > cts_pkg::MAX_HOUR || min_step > cts_pkg::MAX_MINUTE) begin
            status_next = cts_pkg::ST_RANGE;
            phase_next  = cts_pkg::PH_DONE;
          end else begin
            phase_next = cts_pkg::PH_SUFFIX;
          end
        end else begin
          // lone minute digit becomes a fresh one-digit run
          hour_next    = minute;
          run_len_next = 2'd1;
          phase_next   = (in_byte == cts_pkg::CH_COLON) ? cts_pkg::PH_COLON
                                                         : cts_pkg::PH_SCAN;
        end
      end
      cts_pkg::PH_SUFFIX: begin
        if (in_byte != cts_pkg::CH_SPACE) begin
          parsed_next = cts_pkg::rebased_minutes(hour, minute, in_byte);
          status_next = cts_pkg::ST_FOUND;
          phase_next  = cts_pkg::PH_DONE;
        end
      end
      cts_pkg::PH_DONE: begin
      end
      default: begin
        if (dig) begin
          phase_next   = cts_pkg::PH_RUN;
          run_len_next = 2'd1;
          hour_next    = {3'b000, d};
        end else begin
          phase_next = cts_pkg::PH_SCAN;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && is_nul)) begin
      phase   <= cts_pkg::PH_SCAN;
      run_len <= 2'd0;
      hour    <= 7'd0;
      minute  <= 7'd0;
      parsed  <= 11'd0;
      status  <= cts_pkg::ST_NONE;
    end else if (advance) begin
      phase   <= phase_next;
      run_len <= run_len_next;
      hour    <= hour_next;
      minute  <= minute_next;
      parsed  <= parsed_next;
      status  <= status_next;
    end
  end

  // time still in the suffix phase is taken with no rebase
  always_comb begin
    txt_end.fire = advance && is_nul;
    txt_end.now  = in_now;
    if (phase == cts_pkg::PH_SUFFIX) begin
      txt_end.status  = cts_pkg::ST_FOUND;
      txt_end.arrival = cts_pkg::rebased_minutes(hour, minute, cts_pkg::CH_NUL);
    end else begin
      txt_end.status  = status;
      txt_end.arrival = parsed;
    end
  end

endmodule

`default_nettype wire

/* src/cts_result.sv */
`default_nettype none

module cts_result (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cts_pkg::text_end_t  txt_end,
  output logic                     res_ready,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [23:0]              m_tdata   // scan_status[1:0], arrival_minute[12:2],
                                             // minutes_until[23:13]
);

  logic [10:0] now_wrapped;
  logic [11:0] until_wide;
  logic [10:0] until_val;
  logic [10:0] arrival_val;
  logic        found;

  assign res_ready = !m_tvalid || m_tready;
  assign found     = (txt_end.status == cts_pkg::ST_FOUND);

  // input never exceeds 2047, so one subtraction brings it into the day
  assign now_wrapped = (txt_end.now >= cts_pkg::DAY_MINUTES)
                       ? txt_end.now - cts_pkg::DAY_MINUTES : txt_end.now;

  always_comb begin
    if (txt_end.arrival >= now_wrapped) begin
      until_wide = {1'b0, txt_end.arrival} - {1'b0, now_wrapped};
    end else begin
      until_wide = {1'b0, txt_end.arrival} + {1'b0, cts_pkg::DAY_MINUTES}
                   - {1'b0, now_wrapped};
    end
  end

  assign until_val   = found ? until_wide[10:0] : 11'd0;
  assign arrival_val = found ? txt_end.arrival : 11'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= txt_end.fire;
    end
  end

  always_ff @(posedge clk) begin
    if (txt_end.fire && res_ready) begin
      m_tdata <= {until_val, arrival_val, txt_end.status};
    end
  end

endmodule

`default_nettype wire

/* verif/clock_time_text_scanner_tb.sv */
`timescale 1ns / 1ps

module clock_time_text_scanner_tb;
  import cts_pkg::*;

  localparam int ITEM_TARGET = 1750;
  localparam int IDLE_LIMIT  = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int DIR_ROWS    = 5;

  // Same layout as m_tdata: minutes_until, arrival_minute, scan_status (msb first)
  typedef struct packed {
    logic [10:0] wait_min;
    logic [10:0] arrival;
    logic [1:0]  status;
  } scan_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;

  always #1 clk = ~clk;

  clock_time_text_scanner i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  scan_result_t expected_scans[$];
  logic [7:0]   text_q[$];
  int           errors       = 0;
  int           results_seen = 0;
  int           items_sent   = 0;
  int           burst_left   = 0;

  // Scanner state as the predictor sees it
  phase_t      pred_phase;
  logic [1:0]  pred_run_len;
  logic [6:0]  pred_hour;
  logic [6:0]  pred_minute;
  logic [10:0] pred_minutes;
  logic [1:0]  pred_status;

  // Directed texts; '#' stands for byte 8'hFF
  string        dir_text [DIR_ROWS] = '{"", "123:4#", "1:2:34p", "12:00 A", "24:59"};
  int unsigned  dir_now  [DIR_ROWS] = '{0, 1439, 2047, 1439, 0};
  bit           dir_typed[DIR_ROWS] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
  scan_result_t dir_exp  [DIR_ROWS] = '{
    scan_result_t'({11'd0, 11'd0, ST_NONE}),
    scan_result_t'({11'd0, 11'd0, ST_NONE}),
    scan_result_t'({11'd0, 11'd0, ST_NONE}),
    scan_result_t'({11'd1, 11'd0, ST_FOUND}),
    scan_result_t'({11'd0, 11'd0, ST_RANGE})
  };

  function automatic void clear_scan_state();
    pred_phase   = PH_SCAN;
    pred_run_len = 2'd0;
    pred_hour    = 7'd0;
    pred_minute  = 7'd0;
    pred_minutes = 11'd0;
    pred_status  = ST_NONE;
  endfunction

  function automatic void close_run(input logic [7:0] c);
    if (pred_run_len <= 2'd2 && c == CH_COLON) pred_phase = PH_COLON;
    else pred_phase = PH_SCAN;
  endfunction

  function automatic void settle_time(input logic [7:0] c);
    int h;
    h = pred_hour;
    if (c == CH_A || c == CH_A_LOW) begin
      if (h == 12) h = 0;
    end else if (c == CH_P || c == CH_P_LOW) begin
      if (h < 12) h = h + 12;
    end
    pred_minutes = 11'(h * 60 + pred_minute);
    pred_status  = ST_FOUND;
    pred_phase   = PH_DONE;
  endfunction

  // Advances the predicted scan by one byte; returns 1 when the byte ends a text
  function automatic bit predict_text_byte(input logic [7:0] c, input logic [10:0] now,
                                           output scan_result_t res);
    bit dig;
    logic [3:0] d;
    int n;
    int arr;
    dig = (c >= CH_ZERO && c <= CH_NINE);
    d   = dig ? 4'(c - CH_ZERO) : 4'd0;
    res = '0;
    if (c != CH_NUL) begin
      case (pred_phase)
        PH_RUN: begin
          if (dig) begin
            if (pred_run_len < 2'd3) begin
              pred_run_len = pred_run_len + 2'd1;
              if (pred_run_len <= 2'd2) pred_hour = 7'(pred_hour * 10 + d);
            end
          end else begin
            close_run(c);
          end
        end
        PH_COLON: begin
          if (dig) begin
            pred_minute = 7'(d);
            pred_phase  = PH_MIN1;
          end else begin
            pred_phase = PH_SCAN;
          end
        end
        PH_MIN1: begin
          if (dig) begin
            pred_minute = 7'(pred_minute * 10 + d);
            if (pred_hour > 7'd23 || pred_minute > 7'd59) begin
              pred_status = ST_RANGE;
              pred_phase  = PH_DONE;
            end else begin
              pred_phase = PH_SUFFIX;
            end
          end else begin
            // lone minute digit becomes a fresh one-digit run
            pred_hour    = pred_minute;
            pred_run_len = 2'd1;
            close_run(c);
          end
        end
        PH_SUFFIX: begin
          if (c != CH_SPACE) settle_time(c);
        end
        PH_DONE: begin
        end
        default: begin
          if (dig) begin
            pred_phase   = PH_RUN;
            pred_run_len = 2'd1;
            pred_hour    = 7'(d);
          end else begin
            pred_phase = PH_SCAN;
          end
        end
      endcase
      return 1'b0;
    end
    if (pred_phase == PH_SUFFIX) settle_time(CH_NUL);
    res.status = pred_status;
    if (pred_status == ST_FOUND) begin
      n = now;
      if (n >= DAY_MINUTES) n = n - DAY_MINUTES;
      arr = pred_minutes;
      res.arrival  = 11'(arr);
      res.wait_min = (arr >= n) ? 11'(arr - n) : 11'(arr + DAY_MINUTES - n);
    end
    clear_scan_state();
    return 1'b1;
  endfunction

  function automatic void add_digits(input int value, input int ndig);
    if (ndig == 2) text_q.push_back(8'(CH_ZERO + value / 10));
    text_q.push_back(8'(CH_ZERO + value % 10));
  endfunction

  function automatic void add_noise(input int count);
    repeat (count) text_q.push_back(8'($urandom_range(1, 255)));
  endfunction

  // Random text, mostly a well-formed time surrounded by random bytes
  function automatic void build_text();
    int kind;
    int hour;
    text_q.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      add_noise($urandom_range(1, 12));
    end else if (kind == 1) begin
      repeat ($urandom_range(3, 4)) add_digits($urandom_range(0, 9), 1);
      text_q.push_back(CH_COLON);
      add_digits($urandom_range(0, 59), 2);
      add_noise($urandom_range(0, 3));
    end else if (kind == 2) begin
      add_digits($urandom_range(0, 9), 1);
      text_q.push_back(CH_COLON);
      add_digits($urandom_range(0, 9), 1);
      text_q.push_back(CH_COLON);
      add_digits($urandom_range(0, 59), 2);
      add_noise($urandom_range(0, 2));
    end else begin
      add_noise($urandom_range(0, 4));
      case ($urandom_range(0, 7))
        0:       hour = $urandom_range(0, 99);
        1:       hour = 12;
        default: hour = $urandom_range(0, 23);
      endcase
      if (hour < 10 && $urandom_range(0, 1)) add_digits(hour, 1);
      else add_digits(hour, 2);
      text_q.push_back(CH_COLON);
      add_digits(($urandom_range(0, 7) == 0) ? $urandom_range(0, 99)
                                             : $urandom_range(0, 59), 2);
      repeat ($urandom_range(0, 2)) text_q.push_back(CH_SPACE);
      case ($urandom_range(0, 5))
        0: text_q.push_back(CH_A);
        1: text_q.push_back(CH_A_LOW);
        2: text_q.push_back(CH_P);
        3: text_q.push_back(CH_P_LOW);
        4: add_noise(1);
        default: ;
      endcase
      add_noise($urandom_range(0, 3));
    end
  endfunction

  function automatic logic [10:0] random_now();
    if ($urandom_range(0, 5) == 0) return 11'($urandom_range(1440, 2047));
    return 11'($urandom_range(0, 1439));
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_byte(input logic [7:0] c, input logic [10:0] now,
                           input bit typed, input scan_result_t typed_res);
    scan_result_t res;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, now, c};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (predict_text_byte(c, now, res)) expected_scans.push_back(typed ? typed_res : res);
    burst_left--;
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [7:0] c;
    int texts;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    texts    = 0;
    clear_scan_state();
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) begin
      for (int i = 0; i < dir_text[r].len(); i++) begin
        c = dir_text[r][i];
        if (c == "#") c = 8'hFF;
        send_byte(c, random_now(), 1'b0, '0);
      end
      send_byte(CH_NUL, 11'(dir_now[r]), dir_typed[r], dir_exp[r]);
    end

    while (items_sent < ITEM_TARGET) begin
      if (texts == 60) begin
        // let the pipe drain completely once
        s_tvalid <= 1'b0;
        while (expected_scans.size() != 0) @(negedge clk);
        burst_left = $urandom_range(1, 40);
      end
      build_text();
      foreach (text_q[i]) send_byte(text_q[i], random_now(), 1'b0, '0);
      send_byte(CH_NUL, random_now(), 1'b0, '0);
      texts++;
    end
    s_tvalid <= 1'b0;

    while (expected_scans.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Receiver: patterned stalls, with one long hold-off to back the block up
  initial begin : result_sink
    logic [15:0] pat;
    int mode;
    bit held;
    m_tready = 1'b0;
    held     = 1'b0;
    wait (!rst);
    forever begin
      if (!held && results_seen >= 30) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          m_tready <= 1'b0;
        end
      end
      mode = $urandom_range(0, 2);
      pat  = 16'($urandom);
      repeat ($urandom_range(10, 150)) begin
        @(negedge clk);
        case (mode)
          0: m_tready <= 1'b1;
          1: begin
            m_tready <= pat[0];
            pat = {pat[0], pat[15:1]};
          end
          default: m_tready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    scan_result_t got;
    scan_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      results_seen++;
      if (expected_scans.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, got %h", $time, m_tdata);
        errors++;
      end else begin
        want = expected_scans.pop_front();
        if (got.status != want.status) begin
          $display("%0t: scan_status expected %0d got %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.arrival != want.arrival) begin
          $display("%0t: arrival_minute expected %0d got %0d", $time, want.arrival,
                   got.arrival);
          errors++;
        end
        if (got.wait_min != want.wait_min) begin
          $display("%0t: minutes_until expected %0d got %0d", $time, want.wait_min,
                   got.wait_min);
          errors++;
        end
      end
    end
  end

  // Ends the run if no transfer happens on either side for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    wait (!rst);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
      else idle++;
    end
    $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* files.f */
src/cts_pkg.sv
src/cts_scan.sv
src/cts_result.sv
src/clock_time_text_scanner.sv
verif/clock_time_text_scanner_tb.sv
